// ===== sv/timer_prescaler_reload_search_defines.svh =====
// Assertion macros for the port-level checker of the timer prescaler reload search.
`ifndef TIMER_PRESCALER_RELOAD_SEARCH_DEFINES_SVH
`define TIMER_PRESCALER_RELOAD_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define TPRS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer prescaler reload search: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define TPRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer prescaler reload search: next-cycle check failed");

`endif

// ===== sv/tprs_pkg.sv =====
// Shared widths, constants and types of the timer prescaler reload search.
package tprs_pkg;

  // Field widths fixed by the interface.
  localparam int PERIOD_W  = 32;
  localparam int MHZ_W     = 10;
  localparam int FIELD_W   = 16;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  // Full tick count product and the width of a count that passed the range check.
  localparam int FULL_W    = PERIOD_W + MHZ_W;
  localparam int CNT_W     = 33;

  // Default counter width and register reset value.
  localparam int COUNTER_BITS_DEF = 16;
  localparam logic [MHZ_W-1:0] MHZ_RESET = MHZ_W'(200);

  // Largest tick count that can be served.
  localparam logic [FULL_W-1:0] MAX_COUNT = FULL_W'(64'h1_0000_0000);

  // Register index decode: the index is the word address bit.
  localparam int   IDX_BIT         = 2;
  localparam logic REG_COUNTER_MHZ = 1'b0;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } tprs_div_stat_t;

endpackage

// ===== sv/timer_prescaler_reload_search.sv =====
// Top level of the timer prescaler reload search with its register port.
//
//  Channel  | Handshake                         | Contents
//  ---------+-----------------------------------+--------------------------------------
//  input    | start high while busy low         | period_us
//  result   | done strobe, one cycle            | prescale_minus_one, reload_minus_one,
//           |                                   | range_error
//  config   | psel & penable & pwrite (pready=1)| counter_mhz at byte address 0
//
// A word that fails the range check returns its result from the CHECK state.
// Otherwise each prescaler candidate goes through ISSUE, the 33-step serial divider
// and an evaluate step in WAIT, then FINISH registers the result; at most
// 2^COUNTER_BITS candidates are tried.
// busy stays high from the cycle after start until the done strobe.
// rst is synchronous and returns counter_mhz to 200; the result cannot be stalled.
module timer_prescaler_reload_search
  import tprs_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PERIOD_W-1:0] period_us,
  output logic                busy,
  output logic                done,
  output logic [FIELD_W-1:0]  prescale_minus_one,
  output logic [FIELD_W-1:0]  reload_minus_one,
  output logic                range_error,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  logic [MHZ_W-1:0] counter_mhz;
  logic             reg_sel;

  assign reg_sel = (paddr[IDX_BIT] == REG_COUNTER_MHZ);

  // Counter clock register, written on the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_mhz <= MHZ_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      counter_mhz <= pwdata[MHZ_W-1:0];
    end
  end

  // Read back; unmapped addresses read zero.
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = DATA_W'(counter_mhz);
    end
  end

  assign pready = 1'b1;

  // Divisor search.
  tprs_search #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_search (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .period_us          (period_us),
    .counter_mhz        (counter_mhz),
    .busy               (busy),
    .done               (done),
    .prescale_minus_one (prescale_minus_one),
    .reload_minus_one   (reload_minus_one),
    .range_error        (range_error)
  );

endmodule

// ===== sv/tprs_div.sv =====
// Restoring serial divider: one quotient bit per cycle, shared by all divisors.
module tprs_div
  import tprs_pkg::*;
#(
  parameter int DW = COUNTER_BITS_DEF + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [CNT_W-1:0]     dividend,
  input  logic [DW-1:0]        divisor,
  output tprs_div_stat_t       stat,
  output logic [CNT_W-1:0]     quotient,
  output logic [DW-1:0]        remainder
);

  localparam int STEP_W = $clog2(CNT_W + 1);
  localparam logic [STEP_W-1:0] STEPS = STEP_W'(CNT_W);

  logic [CNT_W-1:0]  acc;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     dsr;
  logic [STEP_W-1:0] step;
  logic              done;

  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              fits;
  logic [DW-1:0]     rem_next;
  logic [CNT_W-1:0]  acc_next;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem, acc[CNT_W-1]};
    diff     = trial - {1'b0, dsr};
    fits     = (trial >= {1'b0, dsr});
    rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    acc_next = {acc[CNT_W-2:0], fits};
  end

  // Step counter and completion strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= STEPS;
      end else if (step != '0) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits as it shifts.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (step != '0) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign stat.busy = (step != '0);
  assign stat.done = done;
  assign quotient  = acc;
  assign remainder = rem;

endmodule

// ===== sv/tprs_search.sv =====
// Sequencer that walks the prescaler divisors through the shared divider.
module tprs_search
  import tprs_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PERIOD_W-1:0] period_us,
  input  logic [MHZ_W-1:0]    counter_mhz,
  output logic                busy,
  output logic                done,
  output logic [FIELD_W-1:0]  prescale_minus_one,
  output logic [FIELD_W-1:0]  reload_minus_one,
  output logic                range_error
);

  localparam int DW = COUNTER_BITS + 1;
  localparam logic [CNT_W-1:0] LIMIT_Q = CNT_W'(1) << COUNTER_BITS;
  localparam logic [DW-1:0]    LIMIT_I = DW'(1) << COUNTER_BITS;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    ISSUE,
    WAIT,
    FINISH
  } state_t;

  state_t            state;
  logic [FULL_W-1:0] count_full;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  best_rem;
  logic [DW-1:0]     div_i;
  logic [DW-1:0]     best_i;
  logic [DW-1:0]     best_j;

  tprs_div_stat_t    div_stat;
  logic [CNT_W-1:0]  quotient;
  logic [DW-1:0]     remainder;

  logic [CNT_W-1:0]  rem_ext;
  logic              valid_j;
  logic              better;
  logic              exact;
  logic              last;
  logic [DW-1:0]     pre_m1;
  logic [DW-1:0]     rel_m1;
  logic [DW+FIELD_W-1:0] pre_ext;
  logic [DW+FIELD_W-1:0] rel_ext;

  // Shared divider: tick count over the current prescaler candidate.
  tprs_div #(
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == ISSUE),
    .dividend  (count),
    .divisor   (div_i),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // The product i*reload equals count minus the remainder, so the best
  // candidate is the one with the smallest remainder among legal reloads.
  always_comb begin
    rem_ext = CNT_W'(remainder);
    valid_j = (quotient <= LIMIT_Q);
    better  = valid_j && (rem_ext < best_rem);
    exact   = valid_j && (remainder == '0);
    last    = (div_i == LIMIT_I);
    pre_m1  = best_i - DW'(1);
    rel_m1  = best_j - DW'(1);
    pre_ext = {{FIELD_W{1'b0}}, pre_m1};
    rel_ext = {{FIELD_W{1'b0}}, rel_m1};
  end

  // Sequencer with its registered result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            count_full <= FULL_W'(period_us) * FULL_W'(counter_mhz);
            state      <= CHECK;
          end
        end
        CHECK: begin
          if ((count_full == '0) || (count_full > MAX_COUNT)) begin
            done               <= 1'b1;
            range_error        <= 1'b1;
            prescale_minus_one <= '0;
            reload_minus_one   <= '0;
            state              <= IDLE;
          end else begin
            count    <= count_full[CNT_W-1:0];
            best_rem <= count_full[CNT_W-1:0];
            div_i    <= DW'(1);
            state    <= ISSUE;
          end
        end
        ISSUE: begin
          state <= WAIT;
        end
        WAIT: begin
          if (div_stat.done) begin
            if (better) begin
              best_rem <= rem_ext;
              best_i   <= div_i;
              best_j   <= quotient[DW-1:0];
            end
            if (exact || last) begin
              state <= FINISH;
            end else begin
              div_i <= div_i + DW'(1);
              state <= ISSUE;
            end
          end
        end
        FINISH: begin
          done  <= 1'b1;
          state <= IDLE;
          // No legal reload was found when the best remainder is still the count.
          if (best_rem == count) begin
            range_error        <= 1'b1;
            prescale_minus_one <= '0;
            reload_minus_one   <= '0;
          end else begin
            range_error        <= 1'b0;
            prescale_minus_one <= pre_ext[FIELD_W-1:0];
            reload_minus_one   <= rel_ext[FIELD_W-1:0];
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign busy = (state != IDLE);

endmodule

// ===== sv/tprs_chk.sv =====
// Port-level checker for the timer prescaler reload search, bound to the top level.
`include "timer_prescaler_reload_search_defines.svh"

module tprs_chk
  import tprs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [FIELD_W-1:0] prescale_minus_one,
  input logic [FIELD_W-1:0] reload_minus_one,
  input logic               range_error
);

  // A taken word makes the block busy in the next cycle.
  `TPRS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // The result word is shown only as the block goes idle.
  `TPRS_ASSERT_SAME(a_done_idle, done, !busy)
  `TPRS_ASSERT_SAME(a_done_after_busy, done, $past(busy))

  // An error result carries zero in both value fields.
  `TPRS_ASSERT_SAME(a_error_zero, done && range_error,
                    (prescale_minus_one == '0) && (reload_minus_one == '0))

endmodule

bind timer_prescaler_reload_search tprs_chk u_chk (.*);

// ===== dv/timer_setting_checker.sv =====
// Checker for the timer prescaler reload search: predicts every result word and compares it.
module timer_setting_checker
  import tprs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PERIOD_W-1:0] period_us,
  input  logic                busy,
  input  logic                done,
  input  logic [FIELD_W-1:0]  prescale_minus_one,
  input  logic [FIELD_W-1:0]  reload_minus_one,
  input  logic                range_error,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                pready,
  output int unsigned         fault_count,
  output int unsigned         pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result word of the block.
  typedef struct packed {
    logic [FIELD_W-1:0] prescale_m1;
    logic [FIELD_W-1:0] reload_m1;
    logic               err;
  } timer_setting_t;

  localparam logic [63:0] DIVISOR_SPAN = 64'd1 << COUNTER_BITS_DEF;

  logic [MHZ_W-1:0] rate_mhz;
  timer_setting_t   expected_settings[$];
  int unsigned      faults = 0;

  assign fault_count = faults;

  // Search for the first divisor whose product with its reload comes closest to the tick count.
  function automatic timer_setting_t predict_setting(input logic [PERIOD_W-1:0] period,
                                                     input logic [MHZ_W-1:0]    mhz);
    timer_setting_t res;
    logic [63:0]    ticks;
    logic [63:0]    div;
    logic [63:0]    quot;
    logic [63:0]    prod;
    logic [63:0]    best;
    logic [63:0]    best_div;
    logic [63:0]    best_quot;
    res       = '0;
    ticks     = 64'(period) * 64'(mhz);
    best      = '0;
    best_div  = '0;
    best_quot = '0;
    if (ticks == 0 || ticks > 64'(MAX_COUNT)) begin
      res.err = 1'b1;
      return res;
    end
    // The search stops as soon as some divisor splits the count exactly.
    for (div = 1; div <= DIVISOR_SPAN && best != ticks; div++) begin
      quot = ticks / div;
      if (quot <= DIVISOR_SPAN) begin
        prod = div * quot;
        if (prod > best) begin
          best      = prod;
          best_div  = div;
          best_quot = quot;
        end
      end
    end
    if (best == 0) begin
      res.err = 1'b1;
    end else begin
      res.prescale_m1 = FIELD_W'(best_div - 1);
      res.reload_m1   = FIELD_W'(best_quot - 1);
    end
    return res;
  endfunction

  // Track the rate register, queue a prediction per accepted word, and check each result word.
  always @(posedge clk) begin
    timer_setting_t seen;
    timer_setting_t want;
    if (rst) begin
      rate_mhz <= MHZ_RESET;
      expected_settings.delete();
      pending_words <= 0;
    end else begin
      if (done) begin
        seen.prescale_m1 = prescale_minus_one;
        seen.reload_m1   = reload_minus_one;
        seen.err         = range_error;
        if (expected_settings.size() == 0) begin
          if (faults < 10)
            $display("%0t: result word with none expected: prescale %0d reload %0d err %0b",
                     $realtime, seen.prescale_m1, seen.reload_m1, seen.err);
          faults++;
        end else begin
          want = expected_settings.pop_front();
          if (seen !== want) begin
            if (faults < 10)
              $display("%0t: result word mismatch: expected prescale %0d reload %0d err %0b, %s",
                       $realtime, want.prescale_m1, want.reload_m1, want.err,
                       $sformatf("got prescale %0d reload %0d err %0b",
                                 seen.prescale_m1, seen.reload_m1, seen.err));
            faults++;
          end
        end
      end
      if (start && !busy)
        expected_settings.push_back(predict_setting(period_us, rate_mhz));
      if (psel && penable && pwrite && pready && paddr[IDX_BIT] == REG_COUNTER_MHZ)
        rate_mhz <= pwdata[MHZ_W-1:0];
      pending_words <= expected_settings.size();
    end
  end

endmodule

// ===== dv/timer_prescaler_reload_search_tb.sv =====
// Testbench top for the timer prescaler reload search: stimulus, register writes and verdict.
module timer_prescaler_reload_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tprs_pkg::*;

  localparam logic [ADDR_W-1:0] COUNTER_MHZ_ADDR = ADDR_W'(REG_COUNTER_MHZ) << IDX_BIT;
  localparam logic [ADDR_W-1:0] SPARE_ADDR       = ADDR_W'(1) << IDX_BIT;
  // Two full divisor sweeps are run and set the run limit; the rest of the run is small.
  localparam int unsigned RUN_LIMIT     = 20_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_PERCENT  = 15;
  localparam int unsigned PHASE_WORDS   = 25;

  logic                clk;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic [PERIOD_W-1:0] period_us = '0;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic                busy;
  logic                done;
  logic [FIELD_W-1:0]  prescale_minus_one;
  logic [FIELD_W-1:0]  reload_minus_one;
  logic                range_error;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  int unsigned         fault_count;
  int unsigned         pending_words;
  int unsigned         cycle_count = 0;
  logic [MHZ_W-1:0]    rate = MHZ_RESET;
  bit                  steady_flow = 1'b0;

  timer_prescaler_reload_search dut (
    .clk(clk), .rst(rst), .start(start), .period_us(period_us), .busy(busy), .done(done),
    .prescale_minus_one(prescale_minus_one), .reload_minus_one(reload_minus_one),
    .range_error(range_error), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  timer_setting_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .period_us(period_us), .busy(busy), .done(done),
    .prescale_minus_one(prescale_minus_one), .reload_minus_one(reload_minus_one),
    .range_error(range_error), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .fault_count(fault_count), .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random idle cycles ahead of a word, except during the steady stretch.
  function automatic int unsigned idle_gap();
    if (!steady_flow && $urandom_range(99) < IDLE_PERCENT)
      return $urandom_range(5, 1);
    return 0;
  endfunction

  // Periods built so that the divisor search ends early, plus some out-of-range noise.
  function automatic logic [PERIOD_W-1:0] pick_period(input logic [MHZ_W-1:0] mhz);
    int unsigned         reload_max;
    int unsigned         roll;
    logic [PERIOD_W-1:0] noise;
    reload_max = (mhz == 0) ? 65536 : 65536 / mhz;
    roll       = $urandom_range(99);
    if (roll < 55)
      return $urandom_range(reload_max, 1);
    if (roll < 85)
      return $urandom_range(64, 2) * $urandom_range(reload_max, 1);
    if (roll < 90)
      return $urandom_range(1024, 65) * $urandom_range(reload_max, 1);
    if (mhz < 2)
      return '0;
    noise = $urandom | 32'h8000_0000;
    if (FULL_W'(noise) * FULL_W'(mhz) <= MAX_COUNT)
      noise = '1;
    return noise;
  endfunction

  // Offer one word and hold it until the block takes it; start stays high afterward.
  task automatic send_word(input logic [PERIOD_W-1:0] p, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    period_us <= p;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending and wait for every outstanding result word.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic change_rate(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    drain_results();
    write_register(addr, data);
  endtask

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset rate of 200 MHz: zero, all ones, small counts, and counts over the 2^32 limit.
    send_word(32'd0, idle_gap());
    send_word(32'hFFFF_FFFF, idle_gap());
    send_word(32'd1, idle_gap());
    send_word(32'd327, idle_gap());
    send_word(32'd328, idle_gap());
    send_word(32'd21474837, idle_gap());
    send_word(32'h8000_0000, idle_gap());

    // At 1 MHz: largest reload, and a prime count that forces the full sweep.
    change_rate(COUNTER_MHZ_ADDR, 32'd1);
    send_word(32'd1, idle_gap());
    send_word(32'd65536, idle_gap());
    send_word(32'd65537, idle_gap());

    // At 2 MHz with junk in the upper data bits: exactly 2^32 ticks, then just above.
    change_rate(COUNTER_MHZ_ADDR, 32'hFFFF_FC02);
    send_word(32'h8000_0000, idle_gap());
    send_word(32'h8000_0001, idle_gap());

    // Zero rate makes every count zero; a write to the unused address must not change it.
    change_rate(COUNTER_MHZ_ADDR, 32'd0);
    send_word(32'd12345, idle_gap());
    send_word(32'hFFFF_FFFF, idle_gap());
    change_rate(SPARE_ADDR, 32'd77);
    send_word(32'd100, idle_gap());

    // Highest rate.
    change_rate(COUNTER_MHZ_ADDR, 32'd1023);
    send_word(32'd64, idle_gap());
    send_word(32'd65, idle_gap());
    send_word(32'd4198405, idle_gap());
    send_word(32'h5555_5555, idle_gap());

    // Random phases over several rates; the second runs with no idling at all.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: rate = 10'd1023;
        2: rate = 10'd1;
        default: rate = $urandom_range(1023, 2);
      endcase
      change_rate(COUNTER_MHZ_ADDR, ($urandom & ~32'h3FF) | DATA_W'(rate));
      steady_flow = (ph == 1);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 2 && k == PHASE_WORDS / 2)
          drain_results();
        send_word(pick_period(rate), idle_gap());
      end
    end
    steady_flow = 1'b0;

    drain_results();
    if (fault_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
